### hw/rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants for the Newton square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RAD_W         = 32;
    localparam int ROOT_W        = 24;
    localparam int ITER_W        = 10;
    localparam int EST_W         = 31;
    localparam int DIV_STEPS     = 64;
    localparam int DCNT_W        = 6;

    localparam logic [ITER_W-1:0] ITER_RESET = 10'd1000;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_NUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    typedef struct packed {
        logic load;
        logic mul;
        logic num;
        logic div_step;
        logic upd;
        logic out_load;
    } nsr_cmd_t;

    typedef struct packed {
        logic rad_zero;
    } nsr_stat_t;

endpackage

### hw/rtl/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl
// Sequencer: loads a request, runs the Newton steps, hands off the result.
// ----------------------------------------------------------------------------
module nsr_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  logic [nsr_pkg::ITER_W-1:0]   iter_cfg,
    input  nsr_pkg::nsr_stat_t           stat,
    output nsr_pkg::nsr_cmd_t            cmd
);
    import nsr_pkg::*;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              ovld_reg, ovld_next;
    logic              out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovld_reg;
    assign out_free  = !ovld_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        dcnt_next  = dcnt_reg;
        ovld_next  = ovld_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    iter_next = iter_cfg;
                    if (stat.rad_zero || iter_cfg == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd   = 1'b1;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            dcnt_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            dcnt_reg  <= dcnt_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

### hw/rtl/nsr_datapath.sv
// ----------------------------------------------------------------------------
// nsr_datapath
// Estimate, square, signed numerator and bit-serial restoring divider.
// ----------------------------------------------------------------------------
module nsr_datapath
#(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic [nsr_pkg::RAD_W-1:0]    radicand,
    input  nsr_pkg::nsr_cmd_t            cmd,
    output nsr_pkg::nsr_stat_t           stat,
    output logic [nsr_pkg::ROOT_W-1:0]   root
);
    import nsr_pkg::*;

    localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

    logic [EST_W-1:0]  x_reg, x_next;
    logic [63:0]       sv_reg;
    logic [63:0]       sq_reg;
    logic [63:0]       mag_reg, mag_next;
    logic              neg_reg;
    logic [31:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic signed [64:0] num;
    logic [32:0]       rem_sh;
    logic [32:0]       dvs;
    logic signed [66:0] q_s;
    logic signed [66:0] nx;
    logic [EST_W-1:0]  x0;
    logic [EST_W-1:0]  x_clamp;

    assign stat.rad_zero = (radicand == '0);
    assign root          = root_reg;

    assign x0  = (radicand[RAD_W-1:1] == '0) ? EST_W'(1) : radicand[RAD_W-1:1];
    assign num = $signed({1'b0, sq_reg}) - $signed({1'b0, sv_reg});
    assign dvs = {1'b0, x_reg, 1'b0};
    assign rem_sh = {rem_reg, mag_reg[63]};
    assign q_s = neg_reg ? -$signed({3'b000, mag_reg}) : $signed({3'b000, mag_reg});
    assign nx  = $signed({36'd0, x_reg}) - q_s;

    always_comb
    begin
        if (nx < 67'sd1)
            x_clamp = EST_W'(1);
        else if (nx > $signed({36'd0, EST_MAX}))
            x_clamp = EST_MAX;
        else
            x_clamp = nx[EST_W-1:0];
    end

    // the remainder stays below the divisor, so it fits in 32 bits
    always_comb
    begin
        x_next   = x_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        if (cmd.load)
            x_next = stat.rad_zero ? '0 : x0;
        else if (cmd.upd)
            x_next = x_clamp;
        if (cmd.num)
        begin
            mag_next = num[64] ? 64'(-num) : num[63:0];
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= dvs)
            begin
                rem_next = 32'(rem_sh - dvs);
                mag_next = {mag_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                mag_next = {mag_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        if (cmd.load)
            sv_reg <= 64'(radicand) << FRAC_BITS;
        if (cmd.mul)
            sq_reg <= 64'(x_reg) * 64'(x_reg);
        if (cmd.num)
            neg_reg <= num[64];
        if (cmd.out_load)
            root_reg <= (x_reg > EST_W'({ROOT_W{1'b1}})) ? {ROOT_W{1'b1}}
                                                         : x_reg[ROOT_W-1:0];
    end

endmodule

### hw/rtl/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// Newton-Raphson square root of an unsigned fixed-point radicand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: radicand with in_valid / in_stall. One request at a time;
//   in_stall is high while a request is in work.
//   Output channel: root with out_valid / out_stall, held in an output
//   register, so a new request is taken while a result waits.
//   iteration_count_we writes iteration_count (reset 1000); write it idle.
// Sequence:
//   Zero radicand or zero count: straight to the output hand-off.
//   Otherwise N Newton steps for an iteration count N: each step is one
//   multiply, one numerator, a pass of the bit-serial divider over the
//   64-bit numerator magnitude, one update.
// Reset clears the sequencer and the output valid; the count returns to 1000.
// A stalled output holds root; the result of the next request waits in the
// sequencer until the output register is free.
// ----------------------------------------------------------------------------
module newton_square_root
#(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         iteration_count_we,
    input  logic [nsr_pkg::ITER_W-1:0]   iteration_count,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [nsr_pkg::RAD_W-1:0]    radicand,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [nsr_pkg::ROOT_W-1:0]   root
);
    import nsr_pkg::*;

    logic [ITER_W-1:0] iter_reg;
    nsr_cmd_t          cmd;
    nsr_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= ITER_RESET;
        else if (iteration_count_we)
            iter_reg <= iteration_count;
    end

    nsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .iter_cfg  (iter_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    nsr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk      (clk),
        .radicand (radicand),
        .cmd      (cmd),
        .stat     (stat),
        .root     (root)
    );

endmodule

### hw/rtl/nsr_checker.sv
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for newton_square_root.
// ----------------------------------------------------------------------------
module nsr_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [nsr_pkg::ROOT_W-1:0]  root
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while idle did not make block busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root))
        else $error("stalled result changed");

endmodule

bind newton_square_root nsr_checker u_nsr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .root      (root)
);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks newton_square_root against a cycle-free square root predictor.
// A directed table covers zero, one LSB, the largest radicand, saturation and
// the count extremes. Random radicands follow under three idling mixes, with a
// long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;

    import nsr_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  HOLD_CYCLES  = 8000;
    localparam int  N_RAND       = 27;

    typedef struct {
        logic [ITER_W-1:0] count;
        logic [RAD_W-1:0]  rad;
        bit                typed;
        logic [ROOT_W-1:0] exp_root;
    } vec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 iteration_count_we = 1'b0;
    logic [ITER_W-1:0]    iteration_count = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [RAD_W-1:0]     radicand = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ROOT_W-1:0]    root;

    logic [ROOT_W-1:0]    root_q[$];
    logic [ITER_W-1:0]    steps_now = ITER_RESET;
    int                   errors = 0;
    int                   n_req = 0;
    int                   n_res = 0;
    int                   cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    bit                   hold_req = 1'b0;
    int                   hold_cnt = 0;
    vec_t                 dir_tab[$];

    newton_square_root u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .iteration_count_we (iteration_count_we),
        .iteration_count    (iteration_count),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .radicand           (radicand),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .root               (root)
    );

    always #6 clk = ~clk;

    function automatic logic [ROOT_W-1:0] sqrt_newton(logic [RAD_W-1:0] v,
                                                      logic [ITER_W-1:0] steps);
        longint sv;
        longint x;
        longint num;
        longint q;
        if (v == 0)
            return '0;
        sv = longint'({32'd0, v}) <<< 16;
        x  = longint'(v >> 1);
        if (x < 1)
            x = 1;
        for (int i = 0; i < int'(steps); i++)
        begin
            num = x * x - sv;
            q   = num / (2 * x);
            x   = x - q;
            if (x < 1)
                x = 1;
            if (x > 64'h7FFFFFFF)
                x = 64'h7FFFFFFF;
        end
        if (x > 64'hFFFFFF)
            return 24'hFFFFFF;
        return x[ROOT_W-1:0];
    endfunction

    task automatic set_steps(logic [ITER_W-1:0] c);
        while (root_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        iteration_count_we <= 1'b1;
        iteration_count    <= c;
        @(posedge clk);
        iteration_count_we <= 1'b0;
        steps_now = c;
    endtask

    task automatic send(logic [RAD_W-1:0] v, bit typed, logic [ROOT_W-1:0] er);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        root_q.push_back(typed ? er : sqrt_newton(v, steps_now));
        n_req++;
    endtask

    task automatic idle_tx();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [RAD_W-1:0] rand_rad();
        logic [15:0] r;
        case ($urandom_range(4))
            0: return $urandom_range(255);
            1: return 32'hFFFFFFFF - $urandom_range(255);
            2:
            begin
                r = 16'($urandom);
                return {r, 16'd0} >> 8 == 0 ? 32'd1 : (32'(r[7:0]) * 32'(r[7:0])) << 16;
            end
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (hold_req && hold_cnt == 0)
            hold_cnt <= HOLD_CYCLES;
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_res++;
            if (root_q.size() == 0)
            begin
                $error("unexpected result root=%h", root);
                errors++;
            end
            else if (root !== root_q[0])
            begin
                $error("root mismatch: expected %h actual %h", root_q[0], root);
                errors++;
                void'(root_q.pop_front());
            end
            else
                void'(root_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [ITER_W-1:0] cur;
        dir_tab = '{
            '{10'd1000, 32'h00000000, 1, 24'h000000},
            '{10'd1000, 32'h00010000, 0, 24'h0},
            '{10'd1000, 32'h00000001, 0, 24'h0},
            '{10'd1023, 32'hFFFFFFFF, 0, 24'h0},
            '{10'd1023, 32'h00040000, 0, 24'h0},
            '{10'd0,    32'h00000000, 1, 24'h000000},
            '{10'd0,    32'h00000001, 1, 24'h000001},
            '{10'd0,    32'hFFFFFFFF, 1, 24'hFFFFFF},
            '{10'd0,    32'h01FFFFFE, 1, 24'hFFFFFF},
            '{10'd0,    32'h02000000, 1, 24'hFFFFFF},
            '{10'd1,    32'h80000000, 0, 24'h0},
            '{10'd1,    32'h00000002, 0, 24'h0},
            '{10'd1,    32'h55555555, 0, 24'h0},
            '{10'd1,    32'hAAAAAAAA, 0, 24'h0},
            '{10'd40,   32'h00000001, 0, 24'h0},
            '{10'd40,   32'hFFFFFFFF, 0, 24'h0},
            '{10'd40,   32'h00000004, 0, 24'h0},
            '{10'd40,   32'h12345678, 0, 24'h0},
            '{10'd40,   32'h00008000, 0, 24'h0},
            '{10'd40,   32'hFFFF0000, 0, 24'h0}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = ITER_RESET;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].count != cur)
            begin
                idle_tx();
                set_steps(dir_tab[i].count);
                cur = dir_tab[i].count;
            end
            send(dir_tab[i].rad, dir_tab[i].typed, dir_tab[i].exp_root);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 85 : 0;
            rx_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 11 : 0;
            idle_tx();
            set_steps(10'($urandom_range(1, 48)));
            for (int k = 0; k < N_RAND; k++)
            begin
                if (ph == 2 && k == 5)
                    hold_req = 1'b1;
                if (ph == 2 && k == 8)
                    hold_req = 1'b0;
                if (ph == 2 && k == 15)
                begin
                    idle_tx();
                    while (root_q.size() != 0)
                        @(posedge clk);
                end
                send(rand_rad(), 0, '0);
            end
        end
        idle_tx();
        while (root_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d requests sent, %0d roots checked, counts 0, 1, 40, 1000, 1023 and random",
                 n_req, n_res);
        if (errors == 0 && root_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### newton_square_root.f
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_ctrl.sv
hw/rtl/nsr_datapath.sv
hw/rtl/newton_square_root.sv
hw/rtl/nsr_checker.sv
tb/sv/testbench.sv
